@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the base64 stream encoder RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that prop holds at every rising clock edge outside reset.
`define B64_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that cond is never true at a rising clock edge outside reset.
`define B64_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

@@ rtl/core/b64enc_pkg.sv @@
// ----------------------------------------------------------------------------
// b64enc_pkg
// Types, constants and the alphabet function shared by the base64 encoder.
// ----------------------------------------------------------------------------
package b64enc_pkg;

   // Input item: mode selects data byte or end-of-message flush.
   localparam logic MODE_DATA  = 1'b0;
   localparam logic MODE_FLUSH = 1'b1;

   typedef struct packed {
      logic       mode;
      logic [7:0] byte_value;
   } b64enc_req_type;

   typedef struct packed {
      logic [6:0] char_code;
      logic       run_last;
      logic       message_end;
   } b64enc_rsp_type;

   // Byte position within a group of three.
   localparam logic [1:0] PHASE_0 = 2'd0;
   localparam logic [1:0] PHASE_1 = 2'd1;
   localparam logic [1:0] PHASE_2 = 2'd2;

   // Character index within one job.
   localparam logic [1:0] IDX_0 = 2'd0;
   localparam logic [1:0] IDX_1 = 2'd1;
   localparam logic [1:0] IDX_2 = 2'd2;

   localparam logic [6:0] PAD_CHAR = 7'h3D;

   // Work handed from front to back: which characters one item causes.
   typedef enum logic [1:0] {
      JOB_DATA1  = 2'd0,   // one sextet
      JOB_DATA2  = 2'd1,   // two sextets
      JOB_FLUSH1 = 2'd2,   // one sextet, one pad
      JOB_FLUSH2 = 2'd3    // one sextet, two pads
   } b64enc_kind_type;

   typedef struct packed {
      b64enc_kind_type kind;
      logic [5:0]      sextet0;
      logic [5:0]      sextet1;
   } b64enc_job_type;

   typedef struct packed {
      logic not_empty;
      logic not_full;
   } b64enc_qstat_type;

   // Map a six-bit value onto the standard base64 alphabet.
   function automatic logic [6:0] b64enc_char(input logic [5:0] sextet);
      logic [6:0] v;
      logic [6:0] result;
      v = {1'b0, sextet};
      if (sextet < 6'd26) begin
         result = v + 7'd65;       // 'A'..'Z'
      end else if (sextet < 6'd52) begin
         result = v + 7'd71;       // 'a'..'z'
      end else if (sextet < 6'd62) begin
         result = v - 7'd4;        // '0'..'9'
      end else if (sextet == 6'd62) begin
         result = 7'h2B;           // '+'
      end else begin
         result = 7'h2F;           // '/'
      end
      return result;
   endfunction

endpackage

@@ rtl/core/b64enc_front.sv @@
// ----------------------------------------------------------------------------
// b64enc_front
// Accepts items, tracks leftover bits and byte phase, and builds one job per
// item that causes output.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module b64enc_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  b64enc_pkg::b64enc_req_type req_item,
   input  b64enc_pkg::b64enc_qstat_type qstat,
   output logic                       push,
   output b64enc_pkg::b64enc_job_type job
);
   import b64enc_pkg::*;

   logic [1:0] phase_ff, phase_in;
   logic [3:0] left_ff, left_in;
   logic       accept;
   logic       has_job;

   assign req_ready = qstat.not_full;
   assign accept    = req_valid & req_ready;
   assign push      = accept & has_job;

   // Classify the item and compute the job plus the next bit state.
   always_comb begin
      job      = '{kind: JOB_DATA1, sextet0: 6'd0, sextet1: 6'd0};
      has_job  = 1'b0;
      phase_in = PHASE_0;
      left_in  = 4'd0;
      if (req_item.mode == MODE_FLUSH) begin
         unique case (phase_ff)
            PHASE_1: begin
               job.kind    = JOB_FLUSH2;
               job.sextet0 = {left_ff[1:0], 4'd0};
               has_job     = 1'b1;
            end
            PHASE_2: begin
               job.kind    = JOB_FLUSH1;
               job.sextet0 = {left_ff, 2'd0};
               has_job     = 1'b1;
            end
            default: begin
               has_job = 1'b0;
            end
         endcase
      end else begin
         has_job = 1'b1;
         unique case (phase_ff)
            PHASE_1: begin
               job.kind    = JOB_DATA1;
               job.sextet0 = {left_ff[1:0], req_item.byte_value[7:4]};
               left_in     = req_item.byte_value[3:0];
               phase_in    = PHASE_2;
            end
            PHASE_2: begin
               job.kind    = JOB_DATA2;
               job.sextet0 = {left_ff, req_item.byte_value[7:6]};
               job.sextet1 = req_item.byte_value[5:0];
            end
            default: begin
               job.kind    = JOB_DATA1;
               job.sextet0 = req_item.byte_value[7:2];
               left_in     = {2'd0, req_item.byte_value[1:0]};
               phase_in    = PHASE_1;
            end
         endcase
      end
   end

   // Advance the bit state on each accepted item.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_0;
         left_ff  <= 4'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         left_ff  <= left_in;
      end
   end

   `B64_ASSERT_NEVER(a_phase_range, clock, reset, phase_ff == 2'd3, "byte phase reached 3")
   `B64_ASSERT(a_phase0_clean, clock, reset, (phase_ff != PHASE_0) || (left_ff == 4'd0),
               "leftover bits held at start of group")

endmodule

@@ rtl/core/b64enc_queue.sv @@
// ----------------------------------------------------------------------------
// b64enc_queue
// Two-entry job queue between the front and back ends.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module b64enc_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  b64enc_pkg::b64enc_job_type   push_job,
   input  logic                         pop,
   output b64enc_pkg::b64enc_job_type   head_job,
   output b64enc_pkg::b64enc_qstat_type qstat
);
   import b64enc_pkg::*;

   localparam int DEPTH = 2;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   b64enc_job_type   slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   assign qstat.not_empty = (count_ff != '0);
   assign qstat.not_full  = (count_ff != CNT_W'(DEPTH));
   assign head_job        = slot_ff[rd_ptr_ff];

   // Store pushed jobs.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   // Advance pointers and occupancy.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

   `B64_ASSERT(a_no_pop_empty, clock, reset, !pop || qstat.not_empty, "pop from empty queue")
   `B64_ASSERT(a_no_push_full, clock, reset, !push || qstat.not_full, "push into full queue")

endmodule

@@ rtl/core/b64enc_back.sv @@
// ----------------------------------------------------------------------------
// b64enc_back
// Expands queued jobs into characters, one per cycle while rsp_ready allows, into an output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module b64enc_back (
   input  logic                         clock,
   input  logic                         reset,
   input  b64enc_pkg::b64enc_job_type   head_job,
   input  b64enc_pkg::b64enc_qstat_type qstat,
   output logic                         pop,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output b64enc_pkg::b64enc_rsp_type   rsp_item
);
   import b64enc_pkg::*;

   logic [1:0]     idx_ff, idx_in;
   logic           rsp_valid_ff, rsp_valid_in;
   b64enc_rsp_type rsp_item_ff, rsp_item_in;
   logic [1:0]     last_idx;
   logic           is_last;
   logic           load;
   logic [6:0]     char_sel;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // Final character index per job kind.
   always_comb begin
      unique case (head_job.kind)
         JOB_DATA1:  last_idx = IDX_0;
         JOB_DATA2:  last_idx = IDX_1;
         JOB_FLUSH1: last_idx = IDX_1;
         JOB_FLUSH2: last_idx = IDX_2;
         default:    last_idx = IDX_0;
      endcase
   end

   // Pick the character at the current index.
   always_comb begin
      unique case (idx_ff)
         IDX_0:   char_sel = b64enc_char(head_job.sextet0);
         IDX_1:   char_sel = (head_job.kind == JOB_DATA2) ?
                             b64enc_char(head_job.sextet1) : PAD_CHAR;
         default: char_sel = PAD_CHAR;
      endcase
   end

   assign is_last = (idx_ff == last_idx);
   assign load    = qstat.not_empty & (~rsp_valid_ff | rsp_ready);
   assign pop     = load & is_last;

   // Next output register contents and index.
   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_item_in  = rsp_item_ff;
      idx_in       = idx_ff;
      if (load) begin
         rsp_valid_in            = 1'b1;
         rsp_item_in.char_code   = char_sel;
         rsp_item_in.run_last    = is_last;
         rsp_item_in.message_end = is_last &
                                   ((head_job.kind == JOB_FLUSH1) ||
                                    (head_job.kind == JOB_FLUSH2));
         idx_in                  = is_last ? IDX_0 : (idx_ff + 2'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff       <= IDX_0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
      end
   end

   // Hold payload; no reset needed.
   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   `B64_ASSERT(a_end_is_last, clock, reset,
               !rsp_valid_ff || !rsp_item_ff.message_end || rsp_item_ff.run_last,
               "message end without run last")
   `B64_ASSERT(a_idx_in_job, clock, reset, (idx_ff == IDX_0) || qstat.not_empty,
               "character index advanced with no job at head")

endmodule

@@ rtl/core/base64_stream_encoder.sv @@
// ----------------------------------------------------------------------------
// base64_stream_encoder
// Base64 encoder (standard alphabet, '=' padding) over a byte stream.
// ----------------------------------------------------------------------------
// Each data item carries one byte and yields one or two characters; a flush
// item emits the last partial character and pads to a multiple of four, or
// yields nothing when no bits are pending. The output register sends one
// character per cycle while rsp_ready allows, so a byte yields one or two
// characters (three bytes yield four), and that register's rate is what
// sets throughput. A two-entry job queue sits between the byte classifier
// and the character generator, so up to two more items that cause output
// are accepted while a result waits on rsp_ready.
// With the queue empty, an accepted item's job is written to the queue, and
// its first character is then loaded into the output register.
// run_last marks the last character of each item; message_end marks the last
// character of a flush.
module base64_stream_encoder (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  b64enc_pkg::b64enc_req_type req_item,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output b64enc_pkg::b64enc_rsp_type rsp_item
);
   import b64enc_pkg::*;

   b64enc_job_type   push_job;
   b64enc_job_type   head_job;
   b64enc_qstat_type qstat;
   logic             push;
   logic             pop;

   // Classify items and track leftover bits.
   b64enc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .qstat     (qstat),
      .push      (push),
      .job       (push_job)
   );

   // Decouple front and back.
   b64enc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .qstat    (qstat)
   );

   // Emit characters.
   b64enc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_job  (head_job),
      .qstat     (qstat),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

endmodule

@@ test/base64_stream_encoder_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// base64_stream_encoder_checker
// Watches both channels of the base64 stream encoder and checks each output
// character against an encoding predicted from the accepted input items.
// ----------------------------------------------------------------------------
module base64_stream_encoder_checker
   import b64enc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  logic           req_ready,
   input  b64enc_req_type req_item,
   input  logic           rsp_valid,
   input  logic           rsp_ready,
   input  b64enc_rsp_type rsp_item,
   output int             fail_count,
   output int             pending_count
);

   // Standard alphabet, first character in the top byte.
   localparam logic [8*64-1:0] ALPHABET =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   logic [3:0]     held_bits   = '0;
   logic [1:0]     group_phase = PHASE_0;
   b64enc_rsp_type expected_chars[$];
   int             errors_seen = 0;

   function automatic logic [6:0] alphabet_code(input logic [5:0] sextet);
      logic [7:0] code;
      code = ALPHABET[8*(63 - int'(sextet)) +: 8];
      return code[6:0];
   endfunction

   task automatic queue_char(input logic [6:0] code, input logic last, input logic fin);
      b64enc_rsp_type c;
      c.char_code   = code;
      c.run_last    = last;
      c.message_end = fin;
      expected_chars = {expected_chars, c};
   endtask

   // Predict the characters one item causes and advance the encoder state.
   task automatic encode_item(input b64enc_req_type item);
      logic [1:0] ph;
      logic [7:0] b;
      ph = (group_phase == 2'd3) ? PHASE_0 : group_phase;
      b  = item.byte_value;
      if (item.mode == MODE_FLUSH) begin
         case (ph)
            PHASE_1: begin
               queue_char(alphabet_code({held_bits[1:0], 4'b0000}), 1'b0, 1'b0);
               queue_char(PAD_CHAR, 1'b0, 1'b0);
               queue_char(PAD_CHAR, 1'b1, 1'b1);
            end
            PHASE_2: begin
               queue_char(alphabet_code({held_bits, 2'b00}), 1'b0, 1'b0);
               queue_char(PAD_CHAR, 1'b1, 1'b1);
            end
            default: ;
         endcase
         held_bits   = '0;
         group_phase = PHASE_0;
      end else begin
         case (ph)
            PHASE_1: begin
               queue_char(alphabet_code({held_bits[1:0], b[7:4]}), 1'b1, 1'b0);
               held_bits   = b[3:0];
               group_phase = PHASE_2;
            end
            PHASE_2: begin
               queue_char(alphabet_code({held_bits, b[7:6]}), 1'b0, 1'b0);
               queue_char(alphabet_code(b[5:0]), 1'b1, 1'b0);
               held_bits   = '0;
               group_phase = PHASE_0;
            end
            default: begin
               queue_char(alphabet_code(b[7:2]), 1'b1, 1'b0);
               held_bits   = {2'b00, b[1:0]};
               group_phase = PHASE_1;
            end
         endcase
      end
   endtask

   // Predict on each accepted input item, compare each accepted character.
   always @(posedge clock) begin : watch
      b64enc_rsp_type want;
      if (reset) begin
         held_bits   = '0;
         group_phase = PHASE_0;
         expected_chars.delete();
      end else begin
         if (req_valid && req_ready) begin
            encode_item(req_item);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_chars.size() == 0) begin
               $error("unexpected character: char_code %0h run_last %0b message_end %0b",
                      rsp_item.char_code, rsp_item.run_last, rsp_item.message_end);
               errors_seen++;
            end else begin
               want = expected_chars.pop_front();
               if (rsp_item.char_code !== want.char_code) begin
                  $error("char_code: expected %0h, got %0h", want.char_code, rsp_item.char_code);
                  errors_seen++;
               end
               if (rsp_item.run_last !== want.run_last) begin
                  $error("run_last: expected %0b, got %0b", want.run_last, rsp_item.run_last);
                  errors_seen++;
               end
               if (rsp_item.message_end !== want.message_end) begin
                  $error("message_end: expected %0b, got %0b",
                         want.message_end, rsp_item.message_end);
                  errors_seen++;
               end
            end
         end
      end
      fail_count    <= errors_seen;
      pending_count <= expected_chars.size();
   end

endmodule

@@ test/base64_stream_encoder_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// base64_stream_encoder_tb
// Drives directed and random byte messages with flushes into the base64
// stream encoder under varying idle patterns on both channels; a checker
// beside the block predicts and compares every output character.
// ----------------------------------------------------------------------------
module base64_stream_encoder_tb;
   import b64enc_pkg::*;

   localparam int RESET_CYCLES   = 6;
   localparam int CYCLE_LIMIT    = 200000;
   localparam int BYTES_PER_PASS = 50;
   localparam int DRAIN_CYCLES   = 20;

   logic           clock     = 1'b0;
   logic           reset     = 1'b1;
   logic           req_valid = 1'b0;
   logic           req_ready;
   b64enc_req_type req_item  = '0;
   logic           rsp_valid;
   logic           rsp_ready = 1'b0;
   b64enc_rsp_type rsp_item;

   int send_idle_pct = 29;
   int recv_idle_pct = 71;
   int cycle_count   = 0;
   int fail_count;
   int pending_count;

   base64_stream_encoder dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   base64_stream_encoder_checker check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_item      (req_item),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_item      (rsp_item),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Stall the character channel at random
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Offer one item, idling first at random; return at its accept edge.
   task automatic send_item(input logic mode, input logic [7:0] byte_value);
      b64enc_req_type item;
      item.mode       = mode;
      item.byte_value = byte_value;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         req_item  <= b64enc_req_type'(9'($urandom_range(511)));
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_item  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(7))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   initial begin : stimulus
      int pass;
      int bytes_sent;
      int msg_len;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Empty message: flush with nothing pending
      send_item(MODE_FLUSH, 8'hA5);
      // Flush after one byte, then after two
      send_item(MODE_DATA, 8'h00);
      send_item(MODE_FLUSH, 8'h00);
      send_item(MODE_DATA, 8'hFF);
      send_item(MODE_DATA, 8'hFF);
      send_item(MODE_FLUSH, 8'hFF);
      // Full groups, alphabet ends and the '+' character
      send_item(MODE_DATA, 8'hFF);
      send_item(MODE_DATA, 8'hFF);
      send_item(MODE_DATA, 8'hFF);
      send_item(MODE_DATA, 8'h00);
      send_item(MODE_DATA, 8'h00);
      send_item(MODE_DATA, 8'h00);
      send_item(MODE_FLUSH, 8'h5A);
      send_item(MODE_DATA, 8'hFB);
      send_item(MODE_DATA, 8'hEF);
      send_item(MODE_DATA, 8'hBE);
      // Byte carried on a flush is ignored
      send_item(MODE_DATA, 8'h4D);
      send_item(MODE_FLUSH, 8'hFF);
      // Back-to-back flushes
      send_item(MODE_FLUSH, 8'h00);
      send_item(MODE_FLUSH, 8'hFF);

      // Random messages under three idle patterns
      for (pass = 0; pass < 3; pass++) begin
         case (pass)
            0: begin send_idle_pct = 29; recv_idle_pct = 71; end
            1: begin send_idle_pct = 71; recv_idle_pct = 29; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         bytes_sent = 0;
         while (bytes_sent < BYTES_PER_PASS) begin
            msg_len = ($urandom_range(9) == 0) ? $urandom_range(30) : $urandom_range(8);
            repeat (msg_len) begin
               send_item(MODE_DATA, pick_byte());
               bytes_sent++;
            end
            // Mostly a clean flush; sometimes a dropped or a doubled one
            if ($urandom_range(9) != 0) begin
               send_item(MODE_FLUSH, 8'($urandom_range(255)));
            end
            if ($urandom_range(5) == 0) begin
               send_item(MODE_FLUSH, 8'($urandom_range(255)));
            end
         end
      end
      send_item(MODE_FLUSH, pick_byte());
      req_valid <= 1'b0;

      // Drain outstanding characters, then watch for strays
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
